// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the mailbox controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/mbox_pkg.sv =====
// Package: shared types, codes and defaults of the mailbox.
`default_nettype none
package mbox_pkg;
  localparam int unsigned NumEndpointsDef = 16;
  localparam int unsigned QueueDepthDef   = 8;
  localparam int unsigned MaxPayloadDef   = 64;

  localparam logic [2:0] CmdOpen    = 3'd0;
  localparam logic [2:0] CmdClose   = 3'd1;
  localparam logic [2:0] CmdDestroy = 3'd2;
  localparam logic [2:0] CmdSend    = 3'd3;
  localparam logic [2:0] CmdRecv    = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoMbox  = 3'd1;
  localparam logic [2:0] StClosed  = 3'd2;
  localparam logic [2:0] StBadLen  = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;
  localparam logic [2:0] StEmpty   = 3'd5;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;     // capture the accepted beat and its lookups
    logic stage;    // read the head slot's length and sender
    logic commit;   // apply the command to mailbox state
    logic copy;     // move one staged byte into the slot
    logic rd;       // read one payload byte
    logic out_load; // load the output register
    logic out_byte; // output carries a byte (not a status)
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [2:0] cmd;
    logic       last;
    logic       append;   // send beat passes all checks; stores a message on the last beat
    logic       pop;      // receive will pop a message with copy > 0
    logic       copy_done;
    logic       rd_done;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/mbox_datapath.sv =====
// Datapath: mailbox tables, staging buffer, slot memories and output register.
`default_nettype none
module mbox_datapath #(
  parameter int unsigned NumEndpoints = mbox_pkg::NumEndpointsDef,
  parameter int unsigned QueueDepth   = mbox_pkg::QueueDepthDef,
  parameter int unsigned MaxPayload   = mbox_pkg::MaxPayloadDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [2:0]        command_i,
  input  wire logic [15:0]       endpoint_i,
  input  wire logic [15:0]       sender_id_i,
  input  wire logic [7:0]        payload_byte_i,
  input  wire logic              byte_last_i,
  input  wire logic [6:0]        read_limit_i,
  input  wire mbox_pkg::dp_cmd_t cmd_i,
  output mbox_pkg::dp_stat_t     stat_o,
  output logic [2:0]             status_o,
  output logic [7:0]             data_byte_o,
  output logic                   byte_present_o,
  output logic                   run_last_o,
  output logic [15:0]            from_sender_o,
  output logic [6:0]             copied_length_o
);
  import mbox_pkg::*;

  localparam int unsigned EpW   = (NumEndpoints > 1) ? $clog2(NumEndpoints) : 1;
  localparam int unsigned QW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam int unsigned BW    = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned Slots = NumEndpoints * QueueDepth;
  localparam int unsigned SW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned PW    = $clog2(Slots * MaxPayload);

  logic [NumEndpoints-1:0] exists_q, open_q;
  logic [QW-1:0]           head_q  [NumEndpoints];
  logic [CntW-1:0]         count_q [NumEndpoints];

  logic [6:0]  slen_mem [Slots];
  logic [15:0] ssnd_mem [Slots];
  logic [7:0]  pay_mem  [Slots*MaxPayload];
  logic [7:0]  stg_mem  [MaxPayload];
  logic [7:0]  stg_len_q;

  // Captured beat.
  logic [2:0]     c_cmd_q;
  logic           c_last_q, c_live_q, c_open_q, c_valid_q;
  logic [EpW-1:0] c_ep_q;
  logic [15:0]    c_snd_q;
  logic [6:0]     c_lim_q, c_len_q;
  logic [QW-1:0]  c_head_q, c_tail_q;
  logic [CntW-1:0] c_cnt_q;
  logic [7:0]     c_slen_q;
  logic [15:0]    c_from_q;
  logic [6:0]     copy_q, idx_q;
  logic [7:0]     stg_rd_q;
  logic [6:0]     cp_q;

  logic           valid_w;
  logic [EpW-1:0] ep_w;
  assign valid_w = ({16'd0, endpoint_i} < 32'(NumEndpoints));
  assign ep_w    = valid_w ? endpoint_i[EpW-1:0] : '0;

  // Tail position: head plus count, wrapped by one compare and subtract.
  logic [SumW-1:0] tail_sum;
  assign tail_sum = SumW'(head_q[ep_w]) + SumW'(count_q[ep_w]);

  logic [SW-1:0] c_slot_tail, c_slot_head;
  assign c_slot_tail = SW'(32'(c_ep_q) * QueueDepth + 32'(c_tail_q));
  assign c_slot_head = SW'(32'(c_ep_q) * QueueDepth + 32'(c_head_q));

  // Prefetch the next staged byte while copying, hold the current one otherwise.
  logic [6:0] stg_rd_idx;
  assign stg_rd_idx = cmd_i.copy ? cp_q + 7'd1 : cp_q;

  // Send-side computed values.
  logic [7:0] stg_len_next;
  assign stg_len_next = (stg_len_q < 8'(MaxPayload)) ? stg_len_q + 8'd1
                                                     : 8'(MaxPayload + 1);

  logic [2:0] send_st;
  always_comb begin
    priority if (!c_live_q) send_st = StNoMbox;
    else if (!c_open_q) send_st = StClosed;
    else if (c_slen_q == 8'd0 || c_slen_q > 8'(MaxPayload)) send_st = StBadLen;
    else if (32'(c_cnt_q) >= QueueDepth) send_st = StFull;
    else send_st = StOk;
  end

  // Receive-side copy length from slot length and limit.
  logic [6:0] rlen, rcopy;
  assign rlen  = (c_len_q > 7'(MaxPayload)) ? 7'(MaxPayload) : c_len_q;
  assign rcopy = (rlen < c_lim_q) ? rlen : c_lim_q;

  logic [2:0] ctl_st;
  always_comb begin
    unique case (c_cmd_q)
      CmdOpen:  ctl_st = c_valid_q ? StOk : StNoMbox;
      CmdSend:  ctl_st = send_st;
      CmdRecv:  ctl_st = !c_live_q ? StNoMbox : (c_cnt_q == '0) ? StEmpty : StOk;
      default:  ctl_st = c_live_q ? StOk : StNoMbox;
    endcase
  end

  assign stat_o.cmd       = c_cmd_q;
  assign stat_o.last      = c_last_q;
  assign stat_o.append    = (send_st == StOk);
  assign stat_o.pop       = c_live_q && (c_cnt_q != '0) && (rcopy != 7'd0);
  assign stat_o.copy_done = (cp_q + 7'd1 >= c_slen_q[6:0]);
  assign stat_o.rd_done   = (idx_q + 7'd1 >= copy_q);

  // Lookups and staging.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_len_q <= '0;
      c_cmd_q   <= '0;
      c_last_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        c_cmd_q   <= command_i;
        c_last_q  <= byte_last_i;
        if (command_i == CmdSend) begin
          stg_len_q <= byte_last_i ? 8'd0 : stg_len_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_valid_q <= valid_w;
      c_live_q  <= valid_w && exists_q[ep_w];
      c_open_q  <= open_q[ep_w];
      c_ep_q    <= ep_w;
      c_snd_q   <= sender_id_i;
      c_lim_q   <= read_limit_i;
      c_head_q  <= head_q[ep_w];
      c_cnt_q   <= count_q[ep_w];
      c_tail_q  <= QW'((tail_sum >= SumW'(QueueDepth)) ? tail_sum - SumW'(QueueDepth)
                                                       : tail_sum);
      c_slen_q  <= stg_len_next;
      cp_q      <= '0;
      idx_q     <= '0;
      if (command_i == CmdSend && stg_len_q < 8'(MaxPayload)) begin
        stg_mem[stg_len_q[BW-1:0]] <= payload_byte_i;
      end
    end
    // Slot metadata read for receive, in the cycle after load.
    if (cmd_i.commit) begin
      copy_q <= rcopy;
    end
    if (cmd_i.stage) begin
      c_len_q  <= slen_mem[c_slot_head];
      c_from_q <= ssnd_mem[c_slot_head];
    end
    // Copy staging into the slot, one byte a cycle; the last byte is held while the output is busy.
    stg_rd_q <= stg_mem[stg_rd_idx[BW-1:0]];
    if (cmd_i.commit && c_cmd_q == CmdSend && send_st == StOk) begin
      slen_mem[c_slot_tail] <= c_slen_q[6:0];
      ssnd_mem[c_slot_tail] <= c_snd_q;
    end
    if (cmd_i.copy) begin
      pay_mem[PW'(32'(c_slot_tail) * MaxPayload + 32'(cp_q))] <= stg_rd_q;
      cp_q <= cp_q + 7'd1;
    end
    if (cmd_i.rd) begin
      data_byte_o <= pay_mem[PW'(32'(c_slot_head) * MaxPayload + 32'(idx_q))];
      idx_q <= idx_q + 7'd1;
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_byte) begin
        status_o        <= StOk;
        byte_present_o  <= 1'b1;
        run_last_o      <= (idx_q == copy_q);
        from_sender_o   <= c_from_q;
        copied_length_o <= copy_q;
      end else begin
        status_o        <= ctl_st;
        data_byte_o     <= '0;
        byte_present_o  <= 1'b0;
        run_last_o      <= 1'b1;
        from_sender_o   <= (c_cmd_q == CmdRecv && ctl_st == StOk) ? c_from_q : 16'd0;
        copied_length_o <= '0;
      end
    end
  end

  // Mailbox tables.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q <= '0;
      open_q   <= '0;
      for (int i = 0; i < NumEndpoints; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      unique case (c_cmd_q)
        CmdOpen: if (c_valid_q) begin
          if (!c_live_q) begin
            exists_q[c_ep_q] <= 1'b1;
            head_q[c_ep_q]   <= '0;
            count_q[c_ep_q]  <= '0;
          end
          open_q[c_ep_q] <= 1'b1;
        end
        CmdClose: if (c_live_q) open_q[c_ep_q] <= 1'b0;
        CmdDestroy: if (c_live_q) begin
          exists_q[c_ep_q] <= 1'b0;
          open_q[c_ep_q]   <= 1'b0;
          head_q[c_ep_q]   <= '0;
          count_q[c_ep_q]  <= '0;
        end
        CmdSend: if (c_last_q && send_st == StOk) count_q[c_ep_q] <= c_cnt_q + 1'b1;
        CmdRecv: if (c_live_q && c_cnt_q != '0) begin
          head_q[c_ep_q]  <= (32'(c_head_q) + 32'd1 >= QueueDepth) ? '0
                                                                   : c_head_q + QW'(1);
          count_q[c_ep_q] <= c_cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mbox_ctrl.sv =====
// Controller: sequences each accepted beat through lookup, commit, copy or metadata and read, and output.
`default_nettype none
`include "assert_macros.svh"
module mbox_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire mbox_pkg::dp_stat_t stat_i,
  output mbox_pkg::dp_cmd_t       cmd_o
);
  import mbox_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_META, S_COPY, S_READ, S_OUT
  } state_e;

  state_e state_q;
  logic   out_busy_q, more_q;
  logic   in_acc, out_acc, out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign out_free = !out_busy_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_busy_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_acc;
    unique case (state_q)
      S_LOOK: begin
        // Known commands but a non-last send give a status beat; a popping receive gives byte beats.
        cmd_o.stage = 1'b1;
        if (stat_i.cmd == CmdSend && stat_i.append && stat_i.last) begin
          cmd_o.commit = 1'b1;
        end else if (stat_i.cmd == CmdRecv) begin
          cmd_o.commit = 1'b0;
        end else if (stat_i.cmd <= CmdSend && (stat_i.cmd != CmdSend || stat_i.last)
                     && out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.out_load = 1'b1;
        end
      end
      S_META: begin
        if (stat_i.pop) begin
          cmd_o.commit = 1'b1;
        end else if (out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.out_load = 1'b1;
        end
      end
      S_COPY: begin
        // Hold the last byte until the status beat can be loaded.
        cmd_o.copy = !stat_i.copy_done || out_free;
        if (stat_i.copy_done && out_free) cmd_o.out_load = 1'b1;
      end
      S_READ: begin
        if (out_free) cmd_o.rd = 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_byte = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_busy_q <= 1'b0;
      more_q     <= 1'b0;
    end else begin
      if (cmd_o.out_load) out_busy_q <= 1'b1;
      else if (out_acc)   out_busy_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) state_q <= S_LOOK;
        S_LOOK: begin
          if (stat_i.cmd == CmdSend && stat_i.append && stat_i.last) state_q <= S_COPY;
          else if (stat_i.cmd == CmdRecv) state_q <= S_META;
          else if (stat_i.cmd > CmdRecv || (stat_i.cmd == CmdSend && !stat_i.last))
            state_q <= S_IDLE;
          else if (out_free) state_q <= S_IDLE;
        end
        S_META: begin
          if (stat_i.pop) state_q <= S_READ;
          else if (out_free) state_q <= S_IDLE;
        end
        S_COPY: if (stat_i.copy_done && out_free) state_q <= S_IDLE;
        S_READ: if (out_free) begin
          more_q  <= !stat_i.rd_done;
          state_q <= S_OUT;
        end
        S_OUT: if (out_free) state_q <= more_q ? S_READ : S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE)
  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_busy_q && !out_ready_i,
               !cmd_o.out_load)
  `ASSERT_NEXT(a_accept_look, clk_i, rst_ni, in_acc, state_q == S_LOOK)
endmodule
`default_nettype wire

// ===== rtl/core/multi_endpoint_message_mailbox.sv =====
// Top level: per-endpoint bounded message mailboxes.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | command, endpoint, sender, byte, last, limit
//  out     | output    | out_valid_o/out_ready_i| status, byte, present, last, sender, length
//
// One beat at a time: a beat is captured at accept and then looked up; a send
// last byte that stores then copies its staged bytes into the slot (one staged
// byte copied per cycle, the last held while the output is busy; single payload
// memory port); a receive then reads slot metadata and does one memory read and
// one output beat per copied byte. Reset clears mailbox tables and the staging
// length; slot memories are not cleared. A stalled output holds the sequencer.
`default_nettype none
module multi_endpoint_message_mailbox #(
  parameter int unsigned NumEndpoints = mbox_pkg::NumEndpointsDef,
  parameter int unsigned QueueDepth   = mbox_pkg::QueueDepthDef,
  parameter int unsigned MaxPayload   = mbox_pkg::MaxPayloadDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [15:0] endpoint_i,
  input  wire logic [15:0] sender_id_i,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic        byte_last_i,
  input  wire logic [6:0]  read_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       data_byte_o,
  output logic             byte_present_o,
  output logic             run_last_o,
  output logic [15:0]      from_sender_o,
  output logic [6:0]       copied_length_o
);
  import mbox_pkg::*;

  // Command and status bundles between sequencer and datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mbox_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  mbox_datapath #(
    .NumEndpoints(NumEndpoints), .QueueDepth(QueueDepth), .MaxPayload(MaxPayload)
  ) u_dp (
    .clk_i, .rst_ni, .command_i, .endpoint_i, .sender_id_i, .payload_byte_i,
    .byte_last_i, .read_limit_i, .cmd_i(cmd), .stat_o(stat),
    .status_o, .data_byte_o, .byte_present_o, .run_last_o, .from_sender_o,
    .copied_length_o
  );
endmodule
`default_nettype wire
